### hdl/dual_axis_quadrature_counter_macros.svh
// Assertion macros used by the checker file of the quadrature counter.
`ifndef DUAL_AXIS_QUADRATURE_COUNTER_MACROS_SVH
`define DUAL_AXIS_QUADRATURE_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define DAQC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define DAQC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/daqc_pkg.sv
// Shared types, constants and the transition table of the quadrature counter.
package daqc_pkg;

	// Width of the per-axis running counts (4 to 64).
	localparam int COUNT_BITS = 16;
	// Width of the count fields in a result transaction.
	localparam int RESULT_BITS = 16;

	typedef logic signed [COUNT_BITS-1:0] count_t;
	typedef logic signed [RESULT_BITS-1:0] result_t;

	localparam count_t COUNT_MAX = count_t'({1'b0, {(COUNT_BITS-1){1'b1}}});
	localparam count_t COUNT_MIN = count_t'({1'b1, {(COUNT_BITS-1){1'b0}}});

	typedef enum logic [1:0] {
		CMD_SAMPLE  = 2'd0,
		CMD_CONSUME = 2'd1,
		CMD_RESYNC  = 2'd2,
		CMD_STATUS  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STEP_NONE = 2'd0,
		STEP_UP   = 2'd1,
		STEP_DOWN = 2'd2
	} step_t;

	// Indexed by {previous phase, current phase}, phase = {A, B}.
	localparam step_t STEP_TABLE [16] = '{
		STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE,
		STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
		STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
		STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE
	};

	// Per-axis update controls, valid for the one cycle in which an item retires.
	typedef struct packed {
		logic step_en;
		logic clear;
		logic resync;
	} axis_ctrl_t;

endpackage

### hdl/dual_axis_quadrature_counter.sv
// Top level of the two-axis x4 quadrature counter.
//
//   Channel  Handshake                    Payload
//   -------  ---------------------------  ---------------------------------
//   cfg      cfg_valid / cfg_ready        cfg_enable
//   sample   sample_valid / sample_stall  cmd, x_a, x_b, y_a, y_b
//   result   result_valid / result_stall  x_count, y_count, pending
//
// Every sample transaction yields exactly one result transaction, passing
// through the input register and then the result register.
// One item is accepted per cycle while not stalled; the single update stage
// that reads and writes the count, phase and pending registers sets the rate.
// arst_n clears the counts, phases, pending flag, enable and all valid bits.
// A stall on the result side holds the result register and, once the input
// register is also occupied, is passed back as sample_stall.
// cfg_ready is always high; the enable register takes effect on later items.
module dual_axis_quadrature_counter
	import daqc_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_enable,
	input  logic           sample_valid,
	output logic           sample_stall,
	input  logic [1:0]     cmd,
	input  logic           x_a,
	input  logic           x_b,
	input  logic           y_a,
	input  logic           y_b,
	output logic           result_valid,
	input  logic           result_stall,
	output logic signed [RESULT_BITS-1:0] x_count,
	output logic signed [RESULT_BITS-1:0] y_count,
	output logic           pending
);

	// Configuration register.
	logic enable_q;

	// Input register stage.
	logic valid_s1;
	cmd_t cmd_s1;
	logic x_a_s1;
	logic x_b_s1;
	logic y_a_s1;
	logic y_b_s1;

	// Result register stage.
	logic    valid_s2;
	result_t x_count_s2;
	result_t y_count_s2;
	logic    pending_s2;

	// Movement seen since the last clear.
	logic flag_q;

	logic       advance;
	logic       load_s1;
	axis_ctrl_t ctrl;
	result_t    x_cnt;
	result_t    y_cnt;
	logic       x_moved;
	logic       y_moved;
	logic       moved;

	assign cfg_ready = 1'b1;

	// The item in the input register retires when the result register is free
	// or is being emptied in this cycle.
	assign advance      = valid_s1 && (!valid_s2 || !result_stall);
	assign sample_stall = valid_s1 && !advance;
	assign load_s1      = sample_valid && !sample_stall;

	always_comb begin
		ctrl = '0;
		if (advance) begin
			case (cmd_s1)
				CMD_SAMPLE:  ctrl.step_en = enable_q;
				CMD_CONSUME: ctrl.clear   = 1'b1;
				CMD_RESYNC:  ctrl.resync  = 1'b1;
				default:     ctrl         = '0;
			endcase
		end
	end

	daqc_axis u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.pin_a  (x_a_s1),
		.pin_b  (x_b_s1),
		.count  (x_cnt),
		.moved  (x_moved)
	);

	daqc_axis u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.pin_a  (y_a_s1),
		.pin_b  (y_b_s1),
		.count  (y_cnt),
		.moved  (y_moved)
	);

	assign moved = x_moved || y_moved;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			enable_q <= cfg_enable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctrl.clear || ctrl.resync) begin
			flag_q <= 1'b0;
		end else if (moved) begin
			flag_q <= 1'b1;
		end
	end

	// Input register: control bit under reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1 <= cmd_t'(cmd);
			x_a_s1 <= x_a;
			x_b_s1 <= x_b;
			y_a_s1 <= y_a;
			y_b_s1 <= y_b;
		end
	end

	// Result register. A consume shows the counts before they clear, a
	// resync shows zeros, everything else shows the updated state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (ctrl.resync) begin
				x_count_s2 <= '0;
				y_count_s2 <= '0;
				pending_s2 <= 1'b0;
			end else begin
				x_count_s2 <= x_cnt;
				y_count_s2 <= y_cnt;
				pending_s2 <= flag_q || moved;
			end
		end
	end

	assign result_valid = valid_s2;
	assign x_count      = x_count_s2;
	assign y_count      = y_count_s2;
	assign pending      = pending_s2;

endmodule

### hdl/daqc_axis.sv
// One axis: phase register, transition decode and saturating count.
module daqc_axis
	import daqc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  axis_ctrl_t ctrl,
	input  logic       pin_a,
	input  logic       pin_b,
	output result_t    count,
	output logic       moved
);

	logic [1:0] phase_q;
	count_t     total_q;
	count_t     total_upd;
	logic [1:0] phase_new;
	step_t      step;

	assign phase_new = {pin_a, pin_b};
	assign step      = STEP_TABLE[{phase_q, phase_new}];

	always_comb begin
		total_upd = total_q;
		moved     = 1'b0;
		if (ctrl.step_en) begin
			case (step)
				STEP_UP: begin
					moved = 1'b1;
					if (total_q != COUNT_MAX) begin
						total_upd = total_q + count_t'(1);
					end
				end
				STEP_DOWN: begin
					moved = 1'b1;
					if (total_q != COUNT_MIN) begin
						total_upd = total_q - count_t'(1);
					end
				end
				default: begin
					total_upd = total_q;
				end
			endcase
		end
	end

	generate
		if (COUNT_BITS >= RESULT_BITS) begin : g_trunc
			assign count = total_upd[RESULT_BITS-1:0];
		end else begin : g_extend
			assign count = {{(RESULT_BITS-COUNT_BITS){total_upd[COUNT_BITS-1]}}, total_upd};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			total_q <= '0;
		end else begin
			if (ctrl.step_en || ctrl.resync) begin
				phase_q <= phase_new;
			end
			if (ctrl.clear || ctrl.resync) begin
				total_q <= '0;
			end else begin
				total_q <= total_upd;
			end
		end
	end

endmodule

### hdl/daqc_checker.sv
// Port-level checker for the quadrature counter and its bind statement.
`include "dual_axis_quadrature_counter_macros.svh"

module daqc_checker
	import daqc_pkg::*;
(
	input logic                          clk,
	input logic                          arst_n,
	input logic                          sample_valid,
	input logic                          sample_stall,
	input logic [1:0]                    cmd,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic signed [RESULT_BITS-1:0] x_count,
	input logic signed [RESULT_BITS-1:0] y_count,
	input logic                          pending
);

	// A stalled result transaction keeps its payload.
	`DAQC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(x_count) && $stable(y_count) && $stable(pending), "stalled result changed")

	// Backpressure on the sample side only comes from a held result.
	`DAQC_ASSERT_SAME(a_stall_source, sample_stall, result_valid && result_stall, "sample stalled without a held result")

	// An accepted transaction reaches the result port when the result side flows.
	`DAQC_ASSERT_NEXT(a_result_follows, (sample_valid && !sample_stall) ##1 !result_stall, result_valid, "accepted item produced no result")

	// A resync transaction reports cleared counts and flag.
	`DAQC_ASSERT_NEXT(a_resync_zero, (sample_valid && !sample_stall && cmd == CMD_RESYNC) ##1 !result_stall, x_count == 0 && y_count == 0 && !pending, "resync result not cleared")

endmodule

bind dual_axis_quadrature_counter daqc_checker u_daqc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.cmd          (cmd),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.x_count      (x_count),
	.y_count      (y_count),
	.pending      (pending)
);
